// ===== hdl/ccp_pkg.sv =====
package ccp_pkg;

   localparam int KwCount = 16;
   localparam int FlagKws = 10;
   localparam int DeltaCount = 6;
   localparam int KwMaxLen = 22;
   localparam logic [30:0] SatMax = 31'h7FFF_FFFF;

   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_NAME = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;

   localparam logic [1:0] VP_LEAD = 2'd0;
   localparam logic [1:0] VP_DIGITS = 2'd1;
   localparam logic [1:0] VP_DONE = 2'd2;

   localparam int MaxStaleIdx = 4;

   // Registered input item.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
      logic       empty_value;
   } item_type;

   // Keyword lengths.
   function automatic logic [4:0] kw_len(input int k);
      logic [4:0] r;
      case (k)
         0: r = 5'd6;
         1: r = 5'd7;
         2: r = 5'd8;
         3: r = 5'd8;
         4: r = 5'd12;
         5: r = 5'd15;
         6: r = 5'd16;
         7: r = 5'd15;
         8: r = 5'd9;
         9: r = 5'd14;
         10: r = 5'd7;
         11: r = 5'd8;
         12: r = 5'd22;
         13: r = 5'd14;
         14: r = 5'd9;
         15: r = 5'd9;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Keyword text, 22 characters, first character in the top byte.
   function automatic logic [8*KwMaxLen-1:0] kw_text(input int k);
      logic [8*KwMaxLen-1:0] r;
      case (k)
         0: r = {"public", 128'h0};
         1: r = {"private", 120'h0};
         2: r = {"no-store", 112'h0};
         3: r = {"no-cache", 112'h0};
         4: r = {"no-transform", 80'h0};
         5: r = {"must-revalidate", 56'h0};
         6: r = {"proxy-revalidate", 48'h0};
         7: r = {"must-understand", 56'h0};
         8: r = {"immutable", 104'h0};
         9: r = {"only-if-cached", 64'h0};
         10: r = {"max-age", 120'h0};
         11: r = {"s-maxage", 112'h0};
         12: r = "stale-while-revalidate";
         13: r = {"stale-if-error", 64'h0};
         14: r = {"max-stale", 104'h0};
         15: r = {"min-fresh", 104'h0};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Character of keyword k at position p; zero beyond the text.
   function automatic logic [7:0] kw_char(input int k, input logic [4:0] p);
      logic [8*KwMaxLen-1:0] t;
      logic [7:0] r;
      t = kw_text(k);
      r = 8'h00;
      for (int i = 0; i < KwMaxLen; i++) begin
         if (p == 5'(i)) begin
            r = t[8*(KwMaxLen-1-i) +: 8];
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/ccp_parse.sv =====
module ccp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ccp_pkg::item_type    item,
   output logic [9:0]           flags,
   output logic [32*6-1:0]      deltas,
   output logic                 any_known
);
   import ccp_pkg::*;

   logic [9:0]  flag_ff, flag_in;
   logic [31:0] delta_ff [DeltaCount];
   logic [31:0] delta_in [DeltaCount];
   logic        matched_ff, matched_in;
   logic [1:0]  seg_ff, seg_in;
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] alive_ff, alive_in;
   logic        pend_ff, pend_in;
   logic [1:0]  vph_ff, vph_in;
   logic [30:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;

   logic [7:0]  c, lc;
   logic        is_digit, is_ws, fin, do_name, name_reset;
   logic [3:0]  dval;
   logic [34:0] acc_mul;
   logic [15:0] name_alive;

   // Byte classification and the next-state logic of one item.
   always_comb begin
      c = item.text_byte;
      lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
      is_digit = c >= 8'h30 && c <= 8'h39;
      dval = c[3:0];
      is_ws = c == 8'h20 || c == 8'h09;
      acc_mul = {acc_ff, 3'b0} + {2'b0, acc_ff, 1'b0} + {31'b0, dval};

      seg_in = seg_ff;
      pos_in = pos_ff;
      alive_in = alive_ff;
      pend_in = pend_ff;
      vph_in = vph_ff;
      acc_in = acc_ff;
      seen_in = seen_ff;
      fin = 1'b0;
      do_name = 1'b0;
      name_reset = 1'b0;

      if (!item.empty_value) begin
         case (seg_ff)
            PH_NAME: begin
               if (c == ",") begin
                  fin = 1'b1;
               end else if (c == "=") begin
                  seg_in = PH_VALUE;
                  pend_in = 1'b0;
                  vph_in = VP_LEAD;
                  acc_in = '0;
                  seen_in = 1'b0;
               end else if (is_ws) begin
                  pend_in = 1'b1;
               end else begin
                  do_name = 1'b1;
               end
            end
            PH_VALUE: begin
               if (c == ",") begin
                  fin = 1'b1;
               end else if (vph_ff == VP_LEAD) begin
                  if (!(is_ws || c == 8'h22)) begin
                     if (is_digit) begin
                        seen_in = 1'b1;
                        acc_in = {27'b0, dval};
                        vph_in = VP_DIGITS;
                     end else begin
                        vph_in = VP_DONE;
                     end
                  end
               end else if (vph_ff == VP_DIGITS) begin
                  if (is_digit) begin
                     acc_in = (acc_mul > {4'b0, SatMax}) ? SatMax : acc_mul[30:0];
                  end else begin
                     vph_in = VP_DONE;
                  end
               end
            end
            default: begin
               if (!(c == "," || is_ws)) begin
                  name_reset = 1'b1;
                  if (c == "=") begin
                     seg_in = PH_VALUE;
                  end else begin
                     seg_in = PH_NAME;
                     do_name = 1'b1;
                  end
               end
            end
         endcase
      end

      // Name character: narrow the candidate keywords.
      if (name_reset) begin
         pos_in = '0;
         pend_in = 1'b0;
         vph_in = VP_LEAD;
         acc_in = '0;
         seen_in = 1'b0;
      end
      name_alive = name_reset ? 16'hFFFF : ((pend_ff) ? 16'h0 : alive_ff);
      if (name_reset) begin
         alive_in = 16'hFFFF;
      end
      if (do_name) begin
         for (int k = 0; k < KwCount; k++) begin
            if (pos_in >= kw_len(k) || kw_char(k, pos_in) != lc) begin
               name_alive[k] = 1'b0;
            end
         end
         alive_in = name_alive;
         pend_in = 1'b0;
         if (pos_in != 5'd31) begin
            pos_in = pos_in + 5'd1;
         end
      end
   end

   // Directive end: apply the matched keyword to the fields.
   logic       fin_any;
   logic [1:0] fseg;
   always_comb begin
      fin_any = fin || item.last;
      fseg = fin ? seg_ff : seg_in;
      flag_in = flag_ff;
      matched_in = matched_ff;
      for (int d = 0; d < DeltaCount; d++) begin
         delta_in[d] = delta_ff[d];
      end
      if (fin_any && (fseg == PH_NAME || fseg == PH_VALUE)) begin
         // Flag keywords.
         for (int k = 0; k < FlagKws; k++) begin
            if ((fin ? alive_ff[k] : alive_in[k]) &&
                (fin ? pos_ff : pos_in) == kw_len(k)) begin
               matched_in = 1'b1;
               flag_in[k] = 1'b1;
            end
         end
         // Keywords that carry a seconds value.
         for (int d = 0; d < DeltaCount; d++) begin
            if ((fin ? alive_ff[FlagKws+d] : alive_in[FlagKws+d]) &&
                (fin ? pos_ff : pos_in) == kw_len(FlagKws + d)) begin
               matched_in = 1'b1;
               if (fseg == PH_VALUE) begin
                  delta_in[d] = (fin ? seen_ff : seen_in) ?
                     {1'b0, (fin ? acc_ff : acc_in)} : 32'hFFFF_FFFF;
               end else begin
                  delta_in[d] = (d == MaxStaleIdx) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
               end
            end
         end
      end
   end

   // Output view of the finished fields.
   always_comb begin
      flags = flag_in;
      any_known = matched_in;
      for (int d = 0; d < DeltaCount; d++) begin
         deltas[32*d +: 32] = delta_in[d];
      end
   end

   // State registers; a last item returns everything to reset.
   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         flag_ff <= '0;
         matched_ff <= 1'b0;
         for (int d = 0; d < DeltaCount; d++) begin
            delta_ff[d] <= 32'hFFFF_FFFF;
         end
         seg_ff <= PH_SKIP;
         pos_ff <= '0;
         alive_ff <= 16'hFFFF;
         pend_ff <= 1'b0;
         vph_ff <= VP_LEAD;
         acc_ff <= '0;
         seen_ff <= 1'b0;
      end else if (step) begin
         flag_ff <= flag_in;
         matched_ff <= matched_in;
         for (int d = 0; d < DeltaCount; d++) begin
            delta_ff[d] <= delta_in[d];
         end
         if (fin) begin
            seg_ff <= PH_SKIP;
            pos_ff <= '0;
            alive_ff <= 16'hFFFF;
            pend_ff <= 1'b0;
            vph_ff <= VP_LEAD;
            acc_ff <= '0;
            seen_ff <= 1'b0;
         end else begin
            seg_ff <= seg_in;
            pos_ff <= pos_in;
            alive_ff <= alive_in;
            pend_ff <= pend_in;
            vph_ff <= vph_in;
            acc_ff <= acc_in;
            seen_ff <= seen_in;
         end
      end
   end

endmodule

// ===== hdl/cache_control_header_parser_top.sv =====
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_text_byte, req_last, req_empty_value
// rsp      out        rsp_valid, rsp_ready, rsp_directive_flags, rsp_*_secs, rsp_any_known
//
// One byte is taken per cycle. An accepted byte is held in an input register and
// parsed from there; the result of a last byte lands in an output register.
// Reset is synchronous and clears all parse state. The input stalls only while
// the output register holds a result that is not taken and another result is due.
module cache_control_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last,
   input  logic        req_empty_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_directive_flags,
   output logic signed [31:0] rsp_max_age_secs,
   output logic signed [31:0] rsp_shared_max_age_secs,
   output logic signed [31:0] rsp_stale_revalidate_secs,
   output logic signed [31:0] rsp_stale_error_secs,
   output logic signed [31:0] rsp_max_stale_secs,
   output logic signed [31:0] rsp_min_fresh_secs,
   output logic        rsp_any_known
);
   import ccp_pkg::*;

   item_type    item_ff;
   logic        full_ff, full_in;
   logic        ovalid_ff;
   logic        step;
   logic [9:0]  flags;
   logic [191:0] deltas;
   logic        any;
   logic [9:0]  oflags_ff;
   logic [191:0] odeltas_ff;
   logic        oany_ff;

   // The held item moves on unless it would produce a result that cannot land.
   assign step = full_ff && !(item_ff.last && ovalid_ff && !rsp_ready);
   assign req_ready = !full_ff || step;
   assign full_in = (req_valid && req_ready) || (full_ff && !step);

   ccp_parse u_parse (
      .clock(clock), .reset(reset), .step(step), .item(item_ff),
      .flags(flags), .deltas(deltas), .any_known(any)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         if (step && item_ff.last) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         item_ff <= '{text_byte: req_text_byte, last: req_last,
                      empty_value: req_empty_value};
      end
      if (step && item_ff.last) begin
         oflags_ff <= flags;
         odeltas_ff <= deltas;
         oany_ff <= any;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_directive_flags = oflags_ff;
   assign rsp_max_age_secs = odeltas_ff[31:0];
   assign rsp_shared_max_age_secs = odeltas_ff[63:32];
   assign rsp_stale_revalidate_secs = odeltas_ff[95:64];
   assign rsp_stale_error_secs = odeltas_ff[127:96];
   assign rsp_max_stale_secs = odeltas_ff[159:128];
   assign rsp_min_fresh_secs = odeltas_ff[191:160];
   assign rsp_any_known = oany_ff;

endmodule
